[rtl/sui_pkg.sv]
// shared constants for the sorted union block
`timescale 1ns / 1ps

package sui_pkg;

    localparam int VALUE_W    = 64;
    localparam int POS_W      = 6;
    localparam int IDX_W      = 5;
    localparam int OP_W       = 2;
    localparam int LIST_DEPTH = 32;

    localparam logic [OP_W-1:0] OP_PUSH_A = 2'd0;
    localparam logic [OP_W-1:0] OP_PUSH_B = 2'd1;
    localparam logic [OP_W-1:0] OP_RUN    = 2'd2;

endpackage

[rtl/sui_ram.sv]
// list memory: one write port, one registered read port
`timescale 1ns / 1ps

module sui_ram #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [AW-1:0]               i_waddr,
    input  logic [sui_pkg::VALUE_W-1:0] i_wdata,
    input  logic [AW-1:0]               i_raddr,
    output logic [sui_pkg::VALUE_W-1:0] o_rdata
);
    import sui_pkg::*;

    logic [VALUE_W-1:0] r_mem [DEPTH];
    logic [VALUE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/sorted_union_with_index_maps.sv]
// top level: list loading, merge sequencer and result register
//
// Input channel (i_valid / o_ready) carries one command per transaction:
// push a signed 64-bit value to list A, push to list B, or run the union.
// Operation code 3 is accepted and ignored. Pushes can follow back to back;
// a push to a full list is dropped and flagged. A run reads both lists from
// two single-port-read memories and emits the ascending union on the output
// channel (o_valid / i_ready), one result per cycle while the receiver keeps
// up. After the run is accepted, the state register enters the run state and
// the first compare loads the output register. The input stays closed until
// the last result is registered; next head addresses are issued with each
// compare, so the registered memory read adds no gap between results.
// Both lists empty gives one result with o_empty_res set. The last result
// carries o_last, and the run clears both lists and the overflow flag.
// When the receiver stalls, the result stays in the output register and the
// merge holds its place; the memories re-read the same heads.
// Reset clears list counts, flag and output valid; no memory clearing.
`timescale 1ns / 1ps

module sorted_union_with_index_maps #(
    parameter int LIST_DEPTH = sui_pkg::LIST_DEPTH
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [sui_pkg::OP_W-1:0]    i_operation,
    input  logic signed [sui_pkg::VALUE_W-1:0] i_value,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic signed [sui_pkg::VALUE_W-1:0] o_merged_value,
    output logic [sui_pkg::POS_W-1:0]   o_position,
    output logic                        o_from_a,
    output logic                        o_from_b,
    output logic [sui_pkg::IDX_W-1:0]   o_index_a,
    output logic [sui_pkg::IDX_W-1:0]   o_index_b,
    output logic                        o_empty_res,
    output logic                        o_overflow,
    output logic                        o_last
);
    import sui_pkg::*;

    localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CW = $clog2(LIST_DEPTH + 1);

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_state;

    t_state             r_state;
    logic [CW-1:0]      r_count_a;
    logic [CW-1:0]      r_count_b;
    logic               r_dropped;
    logic [CW-1:0]      r_i;
    logic [CW-1:0]      r_j;
    logic [POS_W-1:0]   r_pos;

    logic               r_out_valid;
    logic [VALUE_W-1:0] r_out_value;
    logic [POS_W-1:0]   r_out_pos;
    logic               r_out_from_a;
    logic               r_out_from_b;
    logic [IDX_W-1:0]   r_out_index_a;
    logic [IDX_W-1:0]   r_out_index_b;
    logic               r_out_empty;
    logic               r_out_overflow;
    logic               r_out_last;

    logic               w_in_fire;
    logic               w_has_room_a;
    logic               w_has_room_b;
    logic               w_we_a;
    logic               w_we_b;
    logic [VALUE_W-1:0] w_rdata_a;
    logic [VALUE_W-1:0] w_rdata_b;
    logic [AW-1:0]      w_raddr_a;
    logic [AW-1:0]      w_raddr_b;
    logic               w_step;
    logic               w_has_a;
    logic               w_has_b;
    logic               w_a_lt;
    logic               w_b_lt;
    logic               w_take_a;
    logic               w_take_b;
    logic               w_last;
    logic               w_empty;
    logic [VALUE_W-1:0] w_value;
    logic [CW-1:0]      n_i;
    logic [CW-1:0]      n_j;

    assign o_ready      = (r_state == ST_IDLE);
    assign w_in_fire    = i_valid && o_ready;
    assign w_has_room_a = r_count_a < CW'(LIST_DEPTH);
    assign w_has_room_b = r_count_b < CW'(LIST_DEPTH);
    assign w_we_a       = w_in_fire && (i_operation == OP_PUSH_A) && w_has_room_a;
    assign w_we_b       = w_in_fire && (i_operation == OP_PUSH_B) && w_has_room_b;

    sui_ram #(
        .DEPTH (LIST_DEPTH),
        .AW    (AW)
    ) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (w_we_a),
        .i_waddr (r_count_a[AW-1:0]),
        .i_wdata (i_value),
        .i_raddr (w_raddr_a),
        .o_rdata (w_rdata_a)
    );

    sui_ram #(
        .DEPTH (LIST_DEPTH),
        .AW    (AW)
    ) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (w_we_b),
        .i_waddr (r_count_b[AW-1:0]),
        .i_wdata (i_value),
        .i_raddr (w_raddr_b),
        .o_rdata (w_rdata_b)
    );

    always_comb begin
        w_step   = (r_state == ST_RUN) && (!r_out_valid || i_ready);
        w_has_a  = r_i < r_count_a;
        w_has_b  = r_j < r_count_b;
        w_a_lt   = $signed(w_rdata_a) < $signed(w_rdata_b);
        w_b_lt   = $signed(w_rdata_b) < $signed(w_rdata_a);
        w_take_a = w_has_a && (!w_has_b || !w_b_lt);
        w_take_b = w_has_b && (!w_has_a || !w_a_lt);
        w_empty  = !w_has_a && !w_has_b;
        n_i      = r_i + CW'(w_take_a);
        n_j      = r_j + CW'(w_take_b);
        w_last   = (n_i == r_count_a) && (n_j == r_count_b);
        if (w_take_a) begin
            w_value = w_rdata_a;
        end else if (w_take_b) begin
            w_value = w_rdata_b;
        end else begin
            w_value = '0;
        end
        // address of next cycle's heads
        if (w_step) begin
            w_raddr_a = w_last ? '0 : n_i[AW-1:0];
            w_raddr_b = w_last ? '0 : n_j[AW-1:0];
        end else if (r_state == ST_RUN) begin
            w_raddr_a = r_i[AW-1:0];
            w_raddr_b = r_j[AW-1:0];
        end else begin
            w_raddr_a = '0;
            w_raddr_b = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count_a   <= '0;
            r_count_b   <= '0;
            r_dropped   <= 1'b0;
            r_i         <= '0;
            r_j         <= '0;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_ready && !w_step) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (w_in_fire) begin
                        unique case (i_operation)
                            OP_PUSH_A: begin
                                if (w_has_room_a) begin
                                    r_count_a <= r_count_a + CW'(1);
                                end else begin
                                    r_dropped <= 1'b1;
                                end
                            end
                            OP_PUSH_B: begin
                                if (w_has_room_b) begin
                                    r_count_b <= r_count_b + CW'(1);
                                end else begin
                                    r_dropped <= 1'b1;
                                end
                            end
                            OP_RUN: begin
                                r_state <= ST_RUN;
                                r_i     <= '0;
                                r_j     <= '0;
                                r_pos   <= '0;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                ST_RUN: begin
                    if (w_step) begin
                        r_out_valid    <= 1'b1;
                        r_out_value    <= w_value;
                        r_out_pos      <= w_empty ? '0 : r_pos;
                        r_out_from_a   <= w_take_a;
                        r_out_from_b   <= w_take_b;
                        r_out_index_a  <= w_take_a ? IDX_W'(r_i) : '0;
                        r_out_index_b  <= w_take_b ? IDX_W'(r_j) : '0;
                        r_out_empty    <= w_empty;
                        r_out_overflow <= r_dropped;
                        r_out_last     <= w_last;
                        r_i            <= n_i;
                        r_j            <= n_j;
                        r_pos          <= r_pos + POS_W'(1);
                        if (w_last) begin
                            r_state   <= ST_IDLE;
                            r_count_a <= '0;
                            r_count_b <= '0;
                            r_dropped <= 1'b0;
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_valid        = r_out_valid;
    assign o_merged_value = r_out_value;
    assign o_position     = r_out_pos;
    assign o_from_a       = r_out_from_a;
    assign o_from_b       = r_out_from_b;
    assign o_index_a      = r_out_index_a;
    assign o_index_b      = r_out_index_b;
    assign o_empty_res    = r_out_empty;
    assign o_overflow     = r_out_overflow;
    assign o_last         = r_out_last;

`ifndef SYNTHESIS
    a_heads_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN) |-> ((r_i <= r_count_a) && (r_j <= r_count_b)))
        else $error("merge index beyond list count");

    a_source_xor_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((r_out_from_a || r_out_from_b) != r_out_empty))
        else $error("result source flags disagree with empty flag");

    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_empty) |-> r_out_last)
        else $error("empty result not marked last");

    a_run_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_step && w_last) |=> ((r_count_a == '0) && (r_count_b == '0) && !r_dropped))
        else $error("lists not cleared after run");
`endif

endmodule

[test/sorted_union_with_index_maps_test.sv]
// testbench for sorted_union_with_index_maps: directed and random list loads, checked merges
`timescale 1ns / 1ps

module sorted_union_with_index_maps_test;
    import sui_pkg::*;

    localparam logic [OP_W-1:0] OP_IGNORED = 2'd3;
    localparam int ITEM_TARGET = 350;
    localparam int HOLD_CYCLES = 400;
    localparam int STALL_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 10;

    localparam logic signed [VALUE_W-1:0] VAL_MIN = {1'b1, {(VALUE_W-1){1'b0}}};
    localparam logic signed [VALUE_W-1:0] VAL_MAX = {1'b0, {(VALUE_W-1){1'b1}}};

    typedef struct packed {
        logic signed [VALUE_W-1:0] merged_value;
        logic [POS_W-1:0]          position;
        logic                      from_a;
        logic                      from_b;
        logic [IDX_W-1:0]          index_a;
        logic [IDX_W-1:0]          index_b;
        logic                      empty_res;
        logic                      overflow;
        logic                      last;
    } t_union_result;

    class t_union_checker;
        logic signed [VALUE_W-1:0] list_a [LIST_DEPTH];
        logic signed [VALUE_W-1:0] list_b [LIST_DEPTH];
        int count_a;
        int count_b;
        bit dropped;
        t_union_result expected_union[$];
        int mismatches;
        int checked;
        int runs;
        int drops;

        function void note_command(logic [OP_W-1:0] op, logic signed [VALUE_W-1:0] val);
            int i, j, k, na, nb;
            logic take_a, take_b;
            t_union_result r;
            case (op)
                OP_PUSH_A: begin
                    if (count_a < LIST_DEPTH) begin
                        list_a[count_a] = val;
                        count_a++;
                    end else begin
                        dropped = 1'b1;
                        drops++;
                    end
                end
                OP_PUSH_B: begin
                    if (count_b < LIST_DEPTH) begin
                        list_b[count_b] = val;
                        count_b++;
                    end else begin
                        dropped = 1'b1;
                        drops++;
                    end
                end
                OP_RUN: begin
                    runs++;
                    na = count_a;
                    nb = count_b;
                    i = 0;
                    j = 0;
                    k = 0;
                    if (na == 0 && nb == 0) begin
                        r = '0;
                        r.empty_res = 1'b1;
                        r.overflow = dropped;
                        r.last = 1'b1;
                        expected_union.push_back(r);
                    end
                    while (i < na || j < nb) begin
                        if (i < na && j < nb) begin
                            take_a = list_a[i] <= list_b[j];
                            take_b = list_b[j] <= list_a[i];
                        end else begin
                            take_a = i < na;
                            take_b = !take_a;
                        end
                        r = '0;
                        r.merged_value = take_a ? list_a[i] : list_b[j];
                        r.position = POS_W'(k);
                        r.from_a = take_a;
                        r.from_b = take_b;
                        if (take_a) begin
                            r.index_a = IDX_W'(i);
                            i++;
                        end
                        if (take_b) begin
                            r.index_b = IDX_W'(j);
                            j++;
                        end
                        r.overflow = dropped;
                        r.last = (i == na) && (j == nb);
                        expected_union.push_back(r);
                        k++;
                    end
                    count_a = 0;
                    count_b = 0;
                    dropped = 1'b0;
                end
                default: ;
            endcase
        endfunction

        function void compare_field(string name, int at, logic [VALUE_W-1:0] want,
                                    logic [VALUE_W-1:0] got);
            if (want !== got) begin
                mismatches++;
                $display("%0t: %s mismatch at position %0d: expected %h, actual %h",
                         $time, name, at, want, got);
            end
        endfunction

        function void check_result(t_union_result got);
            t_union_result want;
            checked++;
            if (expected_union.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result: expected none, actual value %h position %0d",
                         $time, got.merged_value, got.position);
                return;
            end
            want = expected_union.pop_front();
            compare_field("merged_value", want.position, want.merged_value, got.merged_value);
            compare_field("position", want.position, want.position, got.position);
            compare_field("from_a", want.position, want.from_a, got.from_a);
            compare_field("from_b", want.position, want.from_b, got.from_b);
            compare_field("index_a", want.position, want.index_a, got.index_a);
            compare_field("index_b", want.position, want.index_b, got.index_b);
            compare_field("empty_res", want.position, want.empty_res, got.empty_res);
            compare_field("overflow", want.position, want.overflow, got.overflow);
            compare_field("last", want.position, want.last, got.last);
        endfunction

        function int pending();
            return expected_union.size();
        endfunction
    endclass

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_valid;
    logic                      o_ready;
    logic [OP_W-1:0]           i_operation;
    logic signed [VALUE_W-1:0] i_value;
    logic                      o_valid;
    logic                      i_ready;
    logic signed [VALUE_W-1:0] o_merged_value;
    logic [POS_W-1:0]          o_position;
    logic                      o_from_a;
    logic                      o_from_b;
    logic [IDX_W-1:0]          o_index_a;
    logic [IDX_W-1:0]          o_index_b;
    logic                      o_empty_res;
    logic                      o_overflow;
    logic                      o_last;

    t_union_checker board;
    t_union_result  seen_result;
    int            items_sent;
    int            commands_sent;
    int            results_seen;
    int            quiet_cycles;
    bit            mid_run;
    bit            held_off;

    sorted_union_with_index_maps u_dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // entered and left at a falling edge
    task automatic send_item(input logic [OP_W-1:0] op, input logic signed [VALUE_W-1:0] val);
        while (!(commands_sent >= 150 && commands_sent < 230) && $urandom_range(99) < 20) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_operation <= op;
        i_value <= val;
        do @(posedge i_clk); while (!o_ready);
        board.note_command(op, val);
        commands_sent++;
        if (op != OP_IGNORED) begin
            items_sent++;
        end
        @(negedge i_clk);
    endtask

    // ascending pool split over the two lists, pushes interleaved, then a run
    task automatic load_and_run(input bit big);
        logic signed [VALUE_W-1:0] pool_val;
        logic signed [VALUE_W-1:0] step;
        logic signed [VALUE_W-1:0] qa[$];
        logic signed [VALUE_W-1:0] qb[$];
        int n, dest, both_pct, a_pct;
        n = big ? $urandom_range(64, 34) : $urandom_range(12, 0);
        both_pct = big ? 5 : 30;
        a_pct = big ? both_pct + $urandom_range(65, 30) : 65;
        pool_val = ($urandom_range(9) == 0) ? VAL_MIN : {$urandom, $urandom};
        for (int e = 0; e < n; e++) begin
            dest = $urandom_range(99);
            if (dest < both_pct) begin
                qa.push_back(pool_val);
                qb.push_back(pool_val);
            end else if (dest < a_pct) begin
                qa.push_back(pool_val);
            end else begin
                qb.push_back(pool_val);
            end
            if ($urandom_range(3) == 0) begin
                step = $urandom_range(2);
            end else begin
                step = {$urandom, $urandom} >> $urandom_range(63, 8);
            end
            pool_val = pool_val + step;
        end
        while (qa.size() != 0 || qb.size() != 0) begin
            if ($urandom_range(19) == 0) begin
                send_item(OP_IGNORED, {$urandom, $urandom});
            end
            if (qb.size() == 0 || (qa.size() != 0 && $urandom_range(1) == 1)) begin
                send_item(OP_PUSH_A, qa.pop_front());
            end else begin
                send_item(OP_PUSH_B, qb.pop_front());
            end
        end
        send_item(OP_RUN, {$urandom, $urandom});
    endtask

    initial begin
        int kind;
        int n;
        board = new;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_operation = OP_PUSH_A;
        i_value = '0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // both lists empty
        send_item(OP_RUN, VAL_MAX);
        send_item(OP_IGNORED, VAL_MAX);
        // extremes, shared heads at both ends
        send_item(OP_PUSH_A, VAL_MIN);
        send_item(OP_PUSH_A, -64'sd1);
        send_item(OP_PUSH_A, 64'sd0);
        send_item(OP_PUSH_A, VAL_MAX);
        send_item(OP_PUSH_B, VAL_MIN);
        send_item(OP_PUSH_B, 64'sd1);
        send_item(OP_PUSH_B, VAL_MAX);
        send_item(OP_IGNORED, VAL_MIN);
        send_item(OP_RUN, 64'sd0);
        // list b only, repeated value
        send_item(OP_PUSH_B, 64'sd5);
        send_item(OP_PUSH_B, 64'sd5);
        send_item(OP_RUN, -64'sd1);
        // unsorted list a
        send_item(OP_PUSH_A, 64'sd10);
        send_item(OP_PUSH_A, -64'sd10);
        send_item(OP_PUSH_B, 64'sd0);
        send_item(OP_RUN, 64'sd0);
        // list a only
        send_item(OP_PUSH_A, 64'sd7);
        send_item(OP_RUN, 64'sd0);
        send_item(OP_IGNORED, 64'sd0);
        send_item(OP_RUN, 64'sd0);

        while (items_sent < ITEM_TARGET) begin
            kind = $urandom_range(99);
            if (kind < 12) begin
                load_and_run(1'b1);
            end else if (kind < 85) begin
                load_and_run(1'b0);
            end else begin
                n = $urandom_range(6, 1);
                repeat (n) send_item(OP_W'($urandom_range(3)), {$urandom, $urandom});
            end
        end
        i_valid <= 1'b0;

        while (board.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d commands in %0d union runs, %0d pushes dropped on full lists",
                 commands_sent, board.runs, board.drops);
        $display("checked %0d results, %0d mismatches", board.checked, board.mismatches);
        if (board.mismatches == 0 && board.pending() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // result side, with one long hold-off in the middle of a run
    initial begin
        i_ready = 1'b0;
        wait (i_rst_n);
        forever begin
            @(negedge i_clk);
            if (!held_off && mid_run && results_seen >= 30) begin
                held_off = 1'b1;
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            i_ready <= (results_seen >= 100 && results_seen < 250) || ($urandom_range(99) >= 20);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            seen_result.merged_value = o_merged_value;
            seen_result.position = o_position;
            seen_result.from_a = o_from_a;
            seen_result.from_b = o_from_b;
            seen_result.index_a = o_index_a;
            seen_result.index_b = o_index_b;
            seen_result.empty_res = o_empty_res;
            seen_result.overflow = o_overflow;
            seen_result.last = o_last;
            board.check_result(seen_result);
            results_seen++;
            mid_run = !o_last;
        end
    end

    initial begin
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

[files.f]
rtl/sui_pkg.sv
rtl/sui_ram.sv
rtl/sorted_union_with_index_maps.sv
test/sorted_union_with_index_maps_test.sv
